// ===== rtl/ptb_pkg.sv =====
// Package: shared types, codes and constants of the periodic timer bank.
`default_nettype none
package ptb_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int MAX_FIRES     = 16;
    localparam int FIRE_W        = $clog2(MAX_FIRES + 1);

    localparam logic [1:0] OP_CREATE  = 2'd0;
    localparam logic [1:0] OP_DESTROY = 2'd1;
    localparam logic [1:0] OP_TICK    = 2'd2;

    localparam logic [1:0] KIND_CREATE  = 2'd0;
    localparam logic [1:0] KIND_DESTROY = 2'd1;
    localparam logic [1:0] KIND_FIRED   = 2'd2;
    localparam logic [1:0] KIND_WAIT    = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NOT_FOUND = 2'd1;
    localparam logic [1:0] ST_FULL      = 2'd2;
    localparam logic [1:0] ST_EMPTY     = 2'd3;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [31:0] now_ms;
        logic [30:0] period_ms;
        logic [15:0] repeat_count;
        logic [4:0]  timer_id;
    } ptb_req_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [1:0]  status;
        logic [4:0]  result_id;
        logic [30:0] wait_ms;
        logic        last;
    } ptb_rsp_t;

    typedef struct packed {
        logic [31:0] deadline;
        logic [30:0] period;
        logic [15:0] remaining;
    } ptb_slot_t;

    typedef struct packed {
        logic        fire;
        logic        live;
        ptb_slot_t   slot;
        logic [30:0] wait_ms;
    } ptb_eval_t;

endpackage
`default_nettype wire

// ===== rtl/ptb_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none
module ptb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/ptb_slot_eval.sv =====
// Tick evaluation of one timer entry: fire test, reload, count-down and wait.
`default_nettype none
module ptb_slot_eval
    import ptb_pkg::*;
(
    input  wire ptb_slot_t    slot,
    input  wire logic         live,
    input  wire logic         fire_ok,
    input  wire logic [31:0]  now_ms,
    output ptb_eval_t         ev
);

    logic [31:0] overdue;
    logic [31:0] reload;
    logic [31:0] eff_deadline;
    logic [31:0] ahead;
    logic        due;
    logic        finite;
    logic        final_fire;

    always_comb
    begin
        overdue      = now_ms - slot.deadline;
        due          = live && !overdue[31] && fire_ok;
        reload       = now_ms + {1'b0, slot.period};
        finite       = slot.remaining != 16'd0;
        final_fire   = due && finite && (slot.remaining <= 16'd1);
        eff_deadline = due ? reload : slot.deadline;
        ahead        = eff_deadline - now_ms;

        ev.fire           = due;
        ev.live           = live && !final_fire;
        ev.slot.deadline  = reload;
        ev.slot.period    = slot.period;
        ev.slot.remaining = (due && finite && !final_fire) ? slot.remaining - 16'd1
                                                           : slot.remaining;
        ev.wait_ms        = ahead[31] ? 31'd0 : ahead[30:0];
    end

endmodule
`default_nettype wire

// ===== rtl/periodic_timer_bank_top.sv =====
// Top level: request sequencer, live bits and slot memory of the timer bank.
// Destroy replies in the cycle after the request; busy stays low.
// Create scans the live bits one slot a cycle and replies at the first free slot, or full at the last.
// Tick reads the slot memory one entry a cycle, then gives the wait report.
// Fired results come one a cycle on the way; busy falls with the final result; no stalls.
// Reset clears the live bits at once; slot memory contents are only used while live.
`default_nettype none
module periodic_timer_bank_top
    import ptb_pkg::*;
#(
    parameter int SLOTS = SLOTS_DEFAULT
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     start,
    input  wire ptb_req_t request,
    output logic          busy,
    output logic          result_strobe,
    output ptb_rsp_t      result
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TW = IW + 6;
    localparam int SW = $bits(ptb_slot_t);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_CREATE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_DRAIN  = 3'd3;
    localparam logic [2:0] S_REPORT = 3'd4;

    logic [2:0]        state_reg, state_next;
    logic [IW-1:0]     idx_reg, idx_next;
    logic              ev_valid_reg, ev_valid_next;
    logic              ev_last_reg, ev_last_next;
    logic [IW-1:0]     ev_idx_reg, ev_idx_next;
    logic [SLOTS-1:0]  live_reg, live_next;
    logic [FIRE_W-1:0] fires_reg, fires_next;
    logic              any_reg, any_next;
    logic [30:0]       best_reg, best_next;
    logic              out_valid_reg, out_valid_next;
    ptb_rsp_t          out_reg, out_next;
    ptb_req_t          req_reg, req_next;

    logic              ram_we;
    logic [IW-1:0]     ram_waddr;
    ptb_slot_t         ram_wdata;
    logic [SW-1:0]     ram_rdata;
    ptb_eval_t         ev;
    logic              accept;
    logic [TW-1:0]     tid_w;
    logic              tid_ok;
    logic [IW-1:0]     tid_idx;

    ptb_ram #(
        .WIDTH (SW),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    ptb_slot_eval u_eval (
        .slot    (ptb_slot_t'(ram_rdata)),
        .live    (ev_valid_reg && live_reg[ev_idx_reg]),
        .fire_ok (fires_reg < FIRE_W'(MAX_FIRES)),
        .now_ms  (req_reg.now_ms),
        .ev      (ev)
    );

    assign busy          = state_reg != S_IDLE;
    assign accept        = start && !busy;
    assign result_strobe = out_valid_reg;
    assign result        = out_reg;

    assign tid_w   = TW'(request.timer_id);
    assign tid_ok  = (tid_w != '0) && (tid_w <= TW'(SLOTS));
    assign tid_idx = IW'(tid_w - TW'(1));

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        ev_valid_next  = 1'b0;
        ev_last_next   = 1'b0;
        ev_idx_next    = ev_idx_reg;
        live_next      = live_reg;
        fires_next     = fires_reg;
        any_next       = any_reg;
        best_next      = best_reg;
        req_next       = req_reg;
        out_valid_next = 1'b0;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = ev_idx_reg;
        ram_wdata      = ev.slot;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    req_next   = request;
                    idx_next   = '0;
                    fires_next = '0;
                    any_next   = 1'b0;
                    best_next  = '0;
                    case (request.opcode)
                        OP_CREATE:
                        begin
                            state_next = S_CREATE;
                        end
                        OP_DESTROY:
                        begin
                            out_valid_next = 1'b1;
                            out_next       = '{KIND_DESTROY, ST_NOT_FOUND, 5'd0, 31'd0, 1'b1};
                            if (tid_ok && live_reg[tid_idx])
                            begin
                                live_next[tid_idx] = 1'b0;
                                out_next.status    = ST_OK;
                            end
                        end
                        OP_TICK:
                        begin
                            state_next = S_SCAN;
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_CREATE:
            begin
                if (!live_reg[idx_reg])
                begin
                    ram_we              = 1'b1;
                    ram_waddr           = idx_reg;
                    ram_wdata.deadline  = req_reg.now_ms + {1'b0, req_reg.period_ms};
                    ram_wdata.period    = req_reg.period_ms;
                    ram_wdata.remaining = req_reg.repeat_count;
                    live_next[idx_reg]  = 1'b1;
                    out_valid_next      = 1'b1;
                    out_next            = '{KIND_CREATE, ST_OK,
                                            5'({1'b0, idx_reg} + (IW + 1)'(1)), 31'd0, 1'b1};
                    state_next          = S_IDLE;
                end
                else if (idx_reg == IW'(SLOTS - 1))
                begin
                    out_valid_next = 1'b1;
                    out_next       = '{KIND_CREATE, ST_FULL, 5'd0, 31'd0, 1'b1};
                    state_next     = S_IDLE;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_SCAN:
            begin
                ev_valid_next = 1'b1;
                ev_idx_next   = idx_reg;
                ev_last_next  = idx_reg == IW'(SLOTS - 1);
                if (idx_reg == IW'(SLOTS - 1))
                begin
                    state_next = S_DRAIN;
                end
                else
                begin
                    idx_next = idx_reg + IW'(1);
                end
            end
            S_DRAIN:
            begin
                state_next = S_REPORT;
            end
            S_REPORT:
            begin
                out_valid_next = 1'b1;
                out_next       = any_reg ? ptb_rsp_t'{KIND_WAIT, ST_OK, 5'd0, best_reg, 1'b1}
                                         : ptb_rsp_t'{KIND_WAIT, ST_EMPTY, 5'd0, 31'd0, 1'b1};
                state_next     = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // fold in the entry read in the previous cycle
        if (ev_valid_reg)
        begin
            if (ev.fire)
            begin
                ram_we                = 1'b1;
                ram_waddr             = ev_idx_reg;
                ram_wdata             = ev.slot;
                live_next[ev_idx_reg] = ev.live;
                fires_next            = fires_reg + FIRE_W'(1);
                out_valid_next        = 1'b1;
                out_next              = '{KIND_FIRED, ST_OK,
                                          5'({1'b0, ev_idx_reg} + (IW + 1)'(1)), 31'd0, 1'b0};
            end
            if (ev.live)
            begin
                any_next = 1'b1;
                if (!any_reg || (ev.wait_ms < best_reg))
                begin
                    best_next = ev.wait_ms;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            idx_reg       <= '0;
            ev_valid_reg  <= 1'b0;
            ev_last_reg   <= 1'b0;
            ev_idx_reg    <= '0;
            live_reg      <= '0;
            fires_reg     <= '0;
            any_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            idx_reg       <= idx_next;
            ev_valid_reg  <= ev_valid_next;
            ev_last_reg   <= ev_last_next;
            ev_idx_reg    <= ev_idx_next;
            live_reg      <= live_next;
            fires_reg     <= fires_next;
            any_reg       <= any_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_reg <= best_next;
        req_reg  <= req_next;
        out_reg  <= out_next;
    end

    a_fire_cap: assert property (@(posedge clk) disable iff (!rst_n)
        fires_reg <= FIRE_W'(MAX_FIRES))
        else $error("fire count above limit");

    a_eval_in_tick: assert property (@(posedge clk) disable iff (!rst_n)
        ev_valid_reg |-> (state_reg == S_SCAN || state_reg == S_DRAIN))
        else $error("entry evaluated outside a tick");

    a_last_eval_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (ev_valid_reg && ev_last_reg) |-> state_reg == S_DRAIN)
        else $error("last entry evaluated out of step");

    a_report_final: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_REPORT |=> result_strobe && result.kind == KIND_WAIT && result.last)
        else $error("wait report missing");

    a_destroy_reply: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && request.opcode == OP_DESTROY) |=>
            result_strobe && result.kind == KIND_DESTROY && !busy)
        else $error("destroy reply missing");

endmodule
`default_nettype wire
